FILE: rtl/core/assert_macros.svh
// assertion macros used by the current loop unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication checked on every clock while out of reset
`define ASSERT_IMPL(lbl, ant, con) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
        else $error("same-cycle check failed");

// next-cycle implication checked on every clock while out of reset
`define ASSERT_NEXT(lbl, ant, con) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
        else $error("next-cycle check failed");

`endif

FILE: rtl/core/hfcl_pkg.sv
// types, codes and hall tables of the hall-sensed current loop
package hfcl_pkg;

    // sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_HALL,
        ST_ELAP,
        ST_DIV,
        ST_ANG,
        ST_TRIG,
        ST_M_IB,
        ST_M_IC,
        ST_M_IC_WB,
        ST_M_BETA,
        ST_M_ID0,
        ST_M_ID1,
        ST_M_IQ0,
        ST_M_IQ1,
        ST_M_INTD,
        ST_M_INTQ,
        ST_M_INTQ_WB,
        ST_M_VA0,
        ST_M_VA1,
        ST_M_VB0,
        ST_M_VB1,
        ST_M_PWMA,
        ST_M_PHASE,
        ST_M_PHASE_WB,
        ST_M_PWMB,
        ST_M_PWMC,
        ST_DONE
    } state_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_CURRENT_OFFSET,
        CFG_AMPS_PER_COUNT,
        CFG_KI_Q,
        CFG_KI_D,
        CFG_INTEG_LIMIT,
        CFG_PWM_CENTER,
        CFG_PWM_GAIN,
        CFG_STALL_TICKS
    } cfg_index_t;

    // spin direction codes
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_BACK = 2'd3;

    // fixed-point constants, Q0.16 except half pi in Q30
    localparam logic [16:0] INV_SQRT3_Q16  = 17'd37837;
    localparam logic [16:0] HALF_SQRT3_Q16 = 17'd56756;
    localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;

    // sector of each hall code in sixths of a turn
    function automatic logic [2:0] sector_sixths(input logic [2:0] h);
        logic [2:0] s;
        unique case (h)
            3'd1:    s = 3'd2;
            3'd2:    s = 3'd4;
            3'd3:    s = 3'd3;
            3'd5:    s = 3'd1;
            3'd6:    s = 3'd5;
            default: s = 3'd0;
        endcase
        return s;
    endfunction

    // bit k set: leaving code k for code h is forward
    function automatic logic [7:0] fwd_from(input logic [2:0] h);
        logic [7:0] m;
        unique case (h)
            3'd1:    m = 8'h20;
            3'd2:    m = 8'h08;
            3'd3:    m = 8'h02;
            3'd4:    m = 8'h40;
            3'd5:    m = 8'h10;
            3'd6:    m = 8'h04;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

    // bit k set: leaving code k for code h is backward
    function automatic logic [7:0] back_from(input logic [2:0] h);
        logic [7:0] m;
        unique case (h)
            3'd1:    m = 8'h08;
            3'd2:    m = 8'h40;
            3'd3:    m = 8'h04;
            3'd4:    m = 8'h20;
            3'd5:    m = 8'h02;
            3'd6:    m = 8'h10;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

endpackage

FILE: rtl/core/hall_foc_current_loop_unit.sv
// hall-sensed field-oriented current loop, one item per pwm cycle
`include "assert_macros.svh"

// One input item (two shunt codes, hall bits, tick count, q setpoint) gives one
// result item (three pwm compares, measured d/q currents, rotor angle, flags).
// An item occupies the block from its acceptance until the sequencer is idle again, and
// its result is valid once it has moved into the output register. The angle
// interpolation runs a restoring divider, which gives one quotient bit per
// cycle, then one shared 34x26 signed multiplier does all seventeen products of the
// transforms, PI loops and pwm scaling in sequence. s_tready is high only while
// the sequencer is idle. A finished result moves into the output register once that
// register is free, and a new item is accepted while it waits there; a result still
// unaccepted at the end of the next item holds the sequencer in its last state.
// Configuration writes are always taken and belong between items.
module hall_foc_current_loop_unit
    import hfcl_pkg::*;
#(
    parameter int ANGLE_BITS = 16,
    parameter int SINE_DEPTH = 256,
    parameter int PWM_PERIOD = 4000,
    parameter int TICK_BITS  = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // configuration write channel
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [2:0]               cfg_index,
    input  logic [23:0]              cfg_data,
    // input items
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // shunt_c_code, shunt_b_code, hall_bits, now_ticks, target_current
    input  logic [((43 + TICK_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // result items
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // pwm_a, pwm_b, pwm_c, current_d, current_q, rotor_angle, hall_fault, interp_on
    output logic [87:0]              m_tdata
);

    localparam int AB     = ANGLE_BITS;
    localparam int TB     = TICK_BITS;
    localparam int ADDR_W = $clog2(SINE_DEPTH);
    localparam int IDX_W  = $clog2(SINE_DEPTH + 1);
    localparam int CNT_W  = $clog2(ANGLE_BITS);
    localparam int PWM_HI = (PWM_PERIOD < 4095) ? PWM_PERIOD : 4095;
    localparam logic [63:0] TURN = 64'd1 << ANGLE_BITS;
    localparam logic [AB-1:0] SEC_ANG1 = AB'((TURN * 1) / 6);
    localparam logic [AB-1:0] SEC_ANG2 = AB'((TURN * 2) / 6);
    localparam logic [AB-1:0] SEC_ANG3 = AB'((TURN * 3) / 6);
    localparam logic [AB-1:0] SEC_ANG4 = AB'((TURN * 4) / 6);
    localparam logic [AB-1:0] SEC_ANG5 = AB'((TURN * 5) / 6);
    localparam logic [AB-1:0] TWELFTH  = AB'(TURN / 12);
    localparam logic [AB-1:0] QUARTER  = AB'(TURN / 4);

    // quarter-wave sine entry, integer taylor series
    function automatic logic [15:0] sine_entry(input int i);
        logic [63:0] one;
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] s;
        one = 64'd1 << 30;
        t   = (64'(i) * HALF_PI_Q30) / SINE_DEPTH;
        t2  = (t * t) >> 30;
        s   = one - (t2 / 110);
        s   = one - (((t2 * s) >> 30) / 72);
        s   = one - (((t2 * s) >> 30) / 42);
        s   = one - (((t2 * s) >> 30) / 20);
        s   = one - (((t2 * s) >> 30) / 6);
        s   = (t * s) >> 30;
        s   = (s * 64'd65535 + (64'd1 << 29)) >> 30;
        return (s > 64'd65535) ? 16'hFFFF : s[15:0];
    endfunction

    // quarter-wave index of an angle
    function automatic logic [IDX_W-1:0] quarter_index(input logic [AB-1:0] a);
        logic [AB+10:0]   p;
        logic [IDX_W-1:0] idx;
        p   = (AB+11)'(a[AB-3:0]) * (AB+11)'(SINE_DEPTH);
        idx = IDX_W'(p >> (AB - 2));
        return a[AB-2] ? (IDX_W'(SINE_DEPTH) - idx) : idx;
    endfunction

    // round to nearest, arithmetic shift
    function automatic logic signed [61:0] rnd(input logic signed [61:0] x, input int n);
        return (x + (62'sd1 <<< (n - 1))) >>> n;
    endfunction

    // saturate to 16 bits
    function automatic logic signed [15:0] sat16(input logic signed [61:0] x);
        if (x > 62'sd32767) return 16'sh7FFF;
        if (x < -62'sd32768) return 16'sh8000;
        return x[15:0];
    endfunction

    // integrator clamp to +-lim
    function automatic logic signed [31:0] clamp_lim(input logic signed [61:0] x,
                                                     input logic signed [61:0] lim);
        if (x > lim) return 32'(lim);
        if (x < -lim) return 32'(-lim);
        return x[31:0];
    endfunction

    // pwm compare from a phase voltage product
    function automatic logic [11:0] pwm_value(input logic [11:0] center,
                                              input logic signed [59:0] p);
        logic signed [61:0] c;
        c = 62'($signed({1'b0, center})) + rnd(62'(p), 29);
        if (c < 62'sd0) return 12'd0;
        if (c > 62'(PWM_HI)) return 12'(PWM_HI);
        return c[11:0];
    endfunction

    // configuration registers
    logic [11:0] current_offset_reg;
    logic [15:0] amps_per_count_reg;
    logic [23:0] ki_q_reg;
    logic [23:0] ki_d_reg;
    logic [14:0] integ_limit_reg;
    logic [11:0] pwm_center_reg;
    logic [11:0] pwm_gain_reg;
    logic [15:0] stall_ticks_reg;

    // loop state
    logic [2:0]         prev_hall_reg;
    logic [1:0]         spin_dir_reg;
    logic               interp_flag_reg;
    logic               fault_flag_reg;
    logic [TB-1:0]      edge_time_reg;
    logic [TB-1:0]      hall_period_reg;
    logic signed [31:0] integ_d_reg;
    logic signed [31:0] integ_q_reg;

    // latched item and work registers
    state_t             state_reg, state_next;
    logic signed [12:0] codec_reg, codeb_reg;
    logic [2:0]         halls_reg;
    logic [TB-1:0]      now_reg;
    logic signed [15:0] target_reg;
    logic [TB+3:0]      rem_reg;
    logic [AB-1:0]      quot_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [AB-1:0]      angle_reg;
    logic               interp_reg;
    logic signed [17:0] sn_reg, cs_reg;
    logic signed [15:0] ib_reg, ic_reg, id_reg, iq_reg;
    logic signed [17:0] alpha_reg, beta_reg;
    logic signed [61:0] acc_reg;
    logic signed [33:0] valpha_reg, vbeta_reg, vb_reg, vc_reg;
    logic [11:0]        pwm_a_reg, pwm_b_reg;
    logic signed [59:0] prod_reg;
    logic               m_tvalid_reg;
    logic [87:0]        m_tdata_reg;

    // shared multiplier operands
    logic               mul_en;
    logic signed [33:0] mul_a;
    logic signed [25:0] mul_b;

    // sine table
    logic [15:0] sine_tab [SINE_DEPTH];
    for (genvar g = 0; g < SINE_DEPTH; g++) begin : g_sine
        assign sine_tab[g] = sine_entry(g);
    end

    // configuration writes
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_offset_reg <= 12'd2050;
            amps_per_count_reg <= 16'd1756;
            ki_q_reg           <= 24'd16777;
            ki_d_reg           <= 24'd1678;
            integ_limit_reg    <= 15'd16384;
            pwm_center_reg     <= 12'd2000;
            pwm_gain_reg       <= 12'd500;
            stall_ticks_reg    <= 16'd5000;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_CURRENT_OFFSET: current_offset_reg <= cfg_data[11:0];
                CFG_AMPS_PER_COUNT: amps_per_count_reg <= cfg_data[15:0];
                CFG_KI_Q:           ki_q_reg           <= cfg_data;
                CFG_KI_D:           ki_d_reg           <= cfg_data;
                CFG_INTEG_LIMIT:    integ_limit_reg    <= cfg_data[14:0];
                CFG_PWM_CENTER:     pwm_center_reg     <= cfg_data[11:0];
                CFG_PWM_GAIN:       pwm_gain_reg       <= cfg_data[11:0];
                CFG_STALL_TICKS:    stall_ticks_reg    <= cfg_data[15:0];
            endcase
        end
    end

    // hall tracking terms
    logic [TB-1:0] period_new;
    logic [1:0]    dir_new;
    logic [TB-1:0] elapsed_now;
    logic [TB+2:0] divisor;
    logic [TB+3:0] rem_dbl;
    logic [7:0]    fwd_mask;
    logic [7:0]    back_mask;
    assign period_new  = now_reg - edge_time_reg;
    assign elapsed_now = now_reg - edge_time_reg;
    assign divisor     = {hall_period_reg, 2'b00} + {1'b0, hall_period_reg, 1'b0};
    assign rem_dbl     = {rem_reg[TB+2:0], 1'b0};
    assign fwd_mask    = fwd_from(halls_reg);
    assign back_mask   = back_from(halls_reg);

    always_comb
    begin
        priority if (fwd_mask[prev_hall_reg])  dir_new = DIR_FWD;
        else if (back_mask[prev_hall_reg])     dir_new = DIR_BACK;
        else                                   dir_new = DIR_NONE;
    end

    // sector angle and interpolated angle
    logic [AB-1:0] sec_angle;
    logic [AB-1:0] angle_new;
    logic          use_interp;
    always_comb
    begin
        unique case (sector_sixths(halls_reg))
            3'd1:    sec_angle = SEC_ANG1;
            3'd2:    sec_angle = SEC_ANG2;
            3'd3:    sec_angle = SEC_ANG3;
            3'd4:    sec_angle = SEC_ANG4;
            3'd5:    sec_angle = SEC_ANG5;
            default: sec_angle = '0;
        endcase
        use_interp = interp_flag_reg && (hall_period_reg != '0);
        if (!use_interp)
            angle_new = sec_angle;
        else if (spin_dir_reg == DIR_BACK)
            angle_new = sec_angle - quot_reg + TWELFTH;
        else
            angle_new = sec_angle + quot_reg - TWELFTH;
    end

    // sine and cosine lookup
    logic [AB-1:0]      cos_angle;
    logic [IDX_W-1:0]   sin_j, cos_j;
    logic [16:0]        sin_mag, cos_mag;
    logic signed [17:0] sin_val, cos_val;
    assign cos_angle = angle_reg + QUARTER;
    assign sin_j     = quarter_index(angle_reg);
    assign cos_j     = quarter_index(cos_angle);
    always_comb
    begin
        sin_mag = (sin_j >= IDX_W'(SINE_DEPTH)) ? 17'd65536
                                                : {1'b0, sine_tab[sin_j[ADDR_W-1:0]]};
        cos_mag = (cos_j >= IDX_W'(SINE_DEPTH)) ? 17'd65536
                                                : {1'b0, sine_tab[cos_j[ADDR_W-1:0]]};
        sin_val = angle_reg[AB-1] ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
        cos_val = cos_angle[AB-1] ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:       if (s_tvalid) state_next = ST_HALL;
            ST_HALL:       state_next = ST_ELAP;
            ST_ELAP:       state_next = ST_DIV;
            ST_DIV:        if (cnt_reg == CNT_W'(AB - 1)) state_next = ST_ANG;
            ST_ANG:        state_next = ST_TRIG;
            ST_TRIG:       state_next = ST_M_IB;
            ST_M_IB:       state_next = ST_M_IC;
            ST_M_IC:       state_next = ST_M_IC_WB;
            ST_M_IC_WB:    state_next = ST_M_BETA;
            ST_M_BETA:     state_next = ST_M_ID0;
            ST_M_ID0:      state_next = ST_M_ID1;
            ST_M_ID1:      state_next = ST_M_IQ0;
            ST_M_IQ0:      state_next = ST_M_IQ1;
            ST_M_IQ1:      state_next = ST_M_INTD;
            ST_M_INTD:     state_next = ST_M_INTQ;
            ST_M_INTQ:     state_next = ST_M_INTQ_WB;
            ST_M_INTQ_WB:  state_next = ST_M_VA0;
            ST_M_VA0:      state_next = ST_M_VA1;
            ST_M_VA1:      state_next = ST_M_VB0;
            ST_M_VB0:      state_next = ST_M_VB1;
            ST_M_VB1:      state_next = ST_M_PWMA;
            ST_M_PWMA:     state_next = ST_M_PHASE;
            ST_M_PHASE:    state_next = ST_M_PHASE_WB;
            ST_M_PHASE_WB: state_next = ST_M_PWMB;
            ST_M_PWMB:     state_next = ST_M_PWMC;
            ST_M_PWMC:     state_next = ST_DONE;
            ST_DONE:       if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    // handshake and multiplier operand select
    always_comb
    begin
        s_tready = (state_reg == ST_IDLE);
        mul_en   = 1'b1;
        mul_a    = '0;
        mul_b    = '0;
        unique case (state_reg)
            ST_M_IB:
            begin
                mul_a = 34'(codeb_reg);
                mul_b = 26'($signed({1'b0, amps_per_count_reg}));
            end
            ST_M_IC:
            begin
                mul_a = 34'(codec_reg);
                mul_b = 26'($signed({1'b0, amps_per_count_reg}));
            end
            ST_M_BETA:
            begin
                mul_a = 34'(ib_reg) - 34'(ic_reg);
                mul_b = 26'($signed({1'b0, INV_SQRT3_Q16}));
            end
            ST_M_ID0:
            begin
                mul_a = 34'(alpha_reg);
                mul_b = 26'(cs_reg);
            end
            ST_M_ID1:
            begin
                mul_a = 34'(beta_reg);
                mul_b = 26'(sn_reg);
            end
            ST_M_IQ0:
            begin
                mul_a = 34'(beta_reg);
                mul_b = 26'(cs_reg);
            end
            ST_M_IQ1:
            begin
                mul_a = 34'(alpha_reg);
                mul_b = 26'(sn_reg);
            end
            ST_M_INTD:
            begin
                mul_a = 34'sd0 - 34'(id_reg);
                mul_b = 26'($signed({1'b0, ki_d_reg}));
            end
            ST_M_INTQ:
            begin
                mul_a = 34'(target_reg) - 34'(iq_reg);
                mul_b = 26'($signed({1'b0, ki_q_reg}));
            end
            ST_M_VA0:
            begin
                mul_a = 34'(integ_d_reg);
                mul_b = 26'(cs_reg);
            end
            ST_M_VA1:
            begin
                mul_a = 34'(integ_q_reg);
                mul_b = 26'(sn_reg);
            end
            ST_M_VB0:
            begin
                mul_a = 34'(integ_d_reg);
                mul_b = 26'(sn_reg);
            end
            ST_M_VB1:
            begin
                mul_a = 34'(integ_q_reg);
                mul_b = 26'(cs_reg);
            end
            ST_M_PWMA:
            begin
                mul_a = valpha_reg;
                mul_b = 26'($signed({1'b0, pwm_gain_reg}));
            end
            ST_M_PHASE:
            begin
                mul_a = vbeta_reg;
                mul_b = 26'($signed({1'b0, HALF_SQRT3_Q16}));
            end
            ST_M_PWMB:
            begin
                mul_a = vb_reg;
                mul_b = 26'($signed({1'b0, pwm_gain_reg}));
            end
            ST_M_PWMC:
            begin
                mul_a = vc_reg;
                mul_b = 26'($signed({1'b0, pwm_gain_reg}));
            end
            default: mul_en = 1'b0;
        endcase
    end

    // shared multiplier, registered product
    always_ff @(posedge clk)
    begin
        if (mul_en)
            prod_reg <= mul_a * mul_b;
    end

    // sequencer state and loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            prev_hall_reg   <= '0;
            spin_dir_reg    <= DIR_NONE;
            interp_flag_reg <= 1'b0;
            fault_flag_reg  <= 1'b0;
            edge_time_reg   <= '0;
            hall_period_reg <= '0;
            integ_d_reg     <= '0;
            integ_q_reg     <= '0;
            cnt_reg         <= '0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == ST_DONE) && (!m_tvalid_reg || m_tready))
                m_tvalid_reg <= 1'b1;
            else if (m_tvalid_reg && m_tready)
                m_tvalid_reg <= 1'b0;
            unique case (state_reg)
                ST_HALL:
                begin
                    if (halls_reg != prev_hall_reg)
                    begin
                        hall_period_reg <= period_new;
                        edge_time_reg   <= now_reg;
                        spin_dir_reg    <= dir_new;
                        interp_flag_reg <= (period_new < TB'(stall_ticks_reg))
                                           && (dir_new != DIR_NONE);
                        fault_flag_reg  <= (halls_reg == 3'd0) || (halls_reg == 3'd7);
                        prev_hall_reg   <= halls_reg;
                    end
                end
                ST_ELAP:
                begin
                    if ({1'b0, elapsed_now} > {hall_period_reg, 1'b0})
                        interp_flag_reg <= 1'b0;
                    cnt_reg <= '0;
                end
                ST_DIV:     cnt_reg <= cnt_reg + 1'b1;
                ST_M_INTQ:
                    integ_d_reg <= clamp_lim(62'(integ_d_reg) + (62'(prod_reg) >>> 3),
                                             62'({integ_limit_reg, 15'd0}));
                ST_M_INTQ_WB:
                    integ_q_reg <= clamp_lim(62'(integ_q_reg) + (62'(prod_reg) >>> 3),
                                             62'({integ_limit_reg, 15'd0}));
                default: ;
            endcase
        end
    end

    // rotor angle on 16 bits
    logic [15:0] angle16;
    if (ANGLE_BITS >= 16) begin : g_ang_hi
        assign angle16 = angle_reg[AB-1 -: 16];
    end
    else begin : g_ang_lo
        assign angle16 = {angle_reg, (16 - ANGLE_BITS)'(0)};
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    codec_reg  <= $signed({1'b0, s_tdata[11:0]})
                                  - $signed({1'b0, current_offset_reg});
                    codeb_reg  <= $signed({1'b0, s_tdata[23:12]})
                                  - $signed({1'b0, current_offset_reg});
                    halls_reg  <= s_tdata[26:24];
                    now_reg    <= s_tdata[26+TB:27];
                    target_reg <= $signed(s_tdata[42+TB:27+TB]);
                end
            end
            ST_ELAP:
            begin
                rem_reg     <= (TB+4)'(elapsed_now);
                quot_reg    <= '0;
            end
            ST_DIV:
            begin
                if (rem_dbl >= {1'b0, divisor})
                begin
                    rem_reg  <= rem_dbl - {1'b0, divisor};
                    quot_reg <= {quot_reg[AB-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_dbl;
                    quot_reg <= {quot_reg[AB-2:0], 1'b0};
                end
            end
            ST_ANG:
            begin
                angle_reg  <= angle_new;
                interp_reg <= use_interp;
            end
            ST_TRIG:
            begin
                sn_reg <= sin_val;
                cs_reg <= cos_val;
            end
            ST_M_IC:    ib_reg <= sat16(rnd(62'(prod_reg), 8));
            ST_M_IC_WB: ic_reg <= sat16(rnd(62'(prod_reg), 8));
            ST_M_BETA:  alpha_reg <= 18'sd0 - 18'(ib_reg) - 18'(ic_reg);
            ST_M_ID0:   beta_reg <= 18'(rnd(62'(prod_reg), 16));
            ST_M_ID1:   acc_reg <= 62'(prod_reg);
            ST_M_IQ0:   id_reg <= sat16(rnd(acc_reg + 62'(prod_reg), 16));
            ST_M_IQ1:   acc_reg <= 62'(prod_reg);
            ST_M_INTD:  iq_reg <= sat16(rnd(acc_reg - 62'(prod_reg), 16));
            ST_M_VA1:   acc_reg <= 62'(prod_reg);
            ST_M_VB0:   valpha_reg <= 34'(rnd(acc_reg - 62'(prod_reg), 16));
            ST_M_VB1:   acc_reg <= 62'(prod_reg);
            ST_M_PWMA:  vbeta_reg <= 34'(rnd(acc_reg + 62'(prod_reg), 16));
            ST_M_PHASE: pwm_a_reg <= pwm_value(pwm_center_reg, prod_reg);
            ST_M_PHASE_WB:
            begin
                vb_reg <= 34'(rnd(-(62'(valpha_reg) <<< 15) + 62'(prod_reg), 16));
                vc_reg <= 34'(rnd(-(62'(valpha_reg) <<< 15) - 62'(prod_reg), 16));
            end
            ST_M_PWMC:  pwm_b_reg <= pwm_value(pwm_center_reg, prod_reg);
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                    m_tdata_reg <= {2'b00, interp_reg, fault_flag_reg, angle16,
                                    iq_reg, id_reg,
                                    pwm_value(pwm_center_reg, prod_reg),
                                    pwm_b_reg, pwm_a_reg};
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // checks
    `ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    `ASSERT_IMPL(a_div_count, state_reg == ST_DIV, cnt_reg <= CNT_W'(AB - 1))
    `ASSERT_IMPL(a_pwm_a_range, m_tvalid_reg, m_tdata_reg[11:0] <= 12'(PWM_HI))
    `ASSERT_NEXT(a_result_held, m_tvalid_reg && !m_tready, m_tvalid_reg)

endmodule

FILE: tb/tb_hall_foc_current_loop_unit.sv
// testbench of the hall-sensed current loop: streamed items checked against a local predictor
`timescale 1ns / 1ps

module tb_hall_foc_current_loop_unit;
    import hfcl_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 80;

    // expected result of one item
    typedef struct {
        logic [11:0] pwm_a;
        logic [11:0] pwm_b;
        logic [11:0] pwm_c;
        logic [15:0] current_d;
        logic [15:0] current_q;
        logic [15:0] rotor_angle;
        logic        hall_fault;
        logic        interp_on;
    } loop_out_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [23:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;

    hall_foc_current_loop_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // mirrored configuration
    logic [11:0] current_offset;
    logic [15:0] amps_per_count;
    logic [23:0] ki_q;
    logic [23:0] ki_d;
    logic [14:0] integ_limit;
    logic [11:0] pwm_center;
    logic [11:0] pwm_gain;
    logic [15:0] stall_ticks;

    // mirrored loop state
    logic [2:0]  last_hall;
    logic [1:0]  rot_dir;
    logic        interp_armed;
    logic        fault_seen;
    logic [31:0] last_edge;
    logic [31:0] sector_period;
    int          integ_d_acc;
    int          integ_q_acc;
    logic [15:0] quarter_sine [256];

    logic [79:0] pending_items [$];
    loop_out_t   expected_out [$];

    int  error_count;
    int  items_sent;
    int  results_seen;
    int  idle_cycles;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  send_hold;
    bit  in_taken;

    // stimulus generator state
    logic [31:0] gen_tick;
    int          gen_pos;
    int          gen_dir;
    logic [2:0]  fwd_order [6] = '{3'd1, 3'd3, 3'd2, 3'd6, 3'd4, 3'd5};

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // quarter-wave table built with the same integer series as the block
    task automatic build_sine();
        longint unsigned one_q30, t, t2, s;
        one_q30 = 64'd1 << 30;
        for (int i = 0; i < 256; i++)
        begin
            t  = (longint'(i) * HALF_PI_Q30) / 256;
            t2 = (t * t) >> 30;
            s  = one_q30 - (t2 / 110);
            s  = one_q30 - ((t2 * s) >> 30) / 72;
            s  = one_q30 - ((t2 * s) >> 30) / 42;
            s  = one_q30 - ((t2 * s) >> 30) / 20;
            s  = one_q30 - ((t2 * s) >> 30) / 6;
            s  = (t * s) >> 30;
            s  = (s * 65535 + (64'd1 << 29)) >> 30;
            quarter_sine[i] = (s > 65535) ? 16'hFFFF : s[15:0];
        end
    endtask

    function automatic longint rnd_shr(longint x, int n);
        return (x + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic longint sat(longint x, longint lo, longint hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    function automatic longint quarter_at(int j);
        return (j >= 256) ? 65536 : longint'(quarter_sine[j]);
    endfunction

    function automatic longint sine_of(longint unsigned ang);
        longint unsigned a;
        int     quad;
        int     idx;
        longint v;
        a    = ang & 64'hFFFF;
        quad = int'(a >> 14);
        idx  = int'(((a & 64'h3FFF) * 256) >> 14);
        v    = quad[0] ? quarter_at(256 - idx) : quarter_at(idx);
        return quad[1] ? -v : v;
    endfunction

    function automatic logic [11:0] compare_of(longint v);
        return 12'(sat(longint'(pwm_center) + rnd_shr(longint'(pwm_gain) * v, 29), 0, 4000));
    endfunction

    // one control step: updates the mirrored state and returns the result
    function automatic loop_out_t run_loop_step(logic [79:0] d);
        loop_out_t       r;
        logic [2:0]      halls;
        logic [31:0]     now;
        logic [7:0]      fmask;
        logic [7:0]      bmask;
        longint          codec, codeb, target, ib, ic, alpha, beta, sn, cs, id, iq;
        longint          lim, acc, valpha, vbeta, va, vb, vc, off;
        longint unsigned elapsed, angle;
        bit              interp;
        codec  = longint'(d[11:0]) - longint'(current_offset);
        codeb  = longint'(d[23:12]) - longint'(current_offset);
        halls  = d[26:24];
        now    = d[58:27];
        target = longint'($signed(d[74:59]));
        interp = 1'b0;

        // hall change bookkeeping
        if (halls != last_hall)
        begin
            sector_period = now - last_edge;
            last_edge     = now;
            fmask         = fwd_from(halls);
            bmask         = back_from(halls);
            if (fmask[last_hall])
                rot_dir = DIR_FWD;
            else if (bmask[last_hall])
                rot_dir = DIR_BACK;
            else
                rot_dir = DIR_NONE;
            interp_armed = (sector_period < stall_ticks) && (rot_dir != DIR_NONE);
            fault_seen   = (halls == 3'd0) || (halls == 3'd7);
            last_hall    = halls;
        end
        elapsed = longint'(32'(now - last_edge));
        if (elapsed > 2 * longint'(sector_period))
            interp_armed = 1'b0;

        // sector angle with optional interpolation
        angle = (longint'(sector_sixths(halls)) << 16) / 6;
        if (interp_armed && sector_period != 0)
        begin
            off = longint'((elapsed << 16) / (6 * longint'(sector_period))) - 5461;
            if (rot_dir == DIR_BACK)
                off = -off;
            angle  = angle + off;
            interp = 1'b1;
        end
        angle = angle & 64'hFFFF;

        // currents, clarke and park
        ib    = sat(rnd_shr(codeb * longint'(amps_per_count), 8), -32768, 32767);
        ic    = sat(rnd_shr(codec * longint'(amps_per_count), 8), -32768, 32767);
        alpha = -ib - ic;
        beta  = rnd_shr((ib - ic) * 37837, 16);
        sn    = sine_of(angle);
        cs    = sine_of(angle + 16384);
        id    = sat(rnd_shr(alpha * cs + beta * sn, 16), -32768, 32767);
        iq    = sat(rnd_shr(beta * cs - alpha * sn, 16), -32768, 32767);

        // integral-only loops
        lim         = longint'(integ_limit) << 15;
        acc         = longint'(integ_d_acc) + (((0 - id) * longint'(ki_d)) >>> 3);
        integ_d_acc = int'(sat(acc, -lim, lim));
        acc         = longint'(integ_q_acc) + (((target - iq) * longint'(ki_q)) >>> 3);
        integ_q_acc = int'(sat(acc, -lim, lim));

        // inverse park and clarke
        valpha = rnd_shr(longint'(integ_d_acc) * cs - longint'(integ_q_acc) * sn, 16);
        vbeta  = rnd_shr(longint'(integ_d_acc) * sn + longint'(integ_q_acc) * cs, 16);
        va     = valpha;
        vb     = rnd_shr(-valpha * 32768 + vbeta * 56756, 16);
        vc     = rnd_shr(-valpha * 32768 - vbeta * 56756, 16);

        r.pwm_a       = compare_of(va);
        r.pwm_b       = compare_of(vb);
        r.pwm_c       = compare_of(vc);
        r.current_d   = 16'(id);
        r.current_q   = 16'(iq);
        r.rotor_angle = angle[15:0];
        r.hall_fault  = fault_seen;
        r.interp_on   = interp;
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
                 results_seen, field, got, want);
        error_count++;
    endtask

    // input acceptance, prediction and result checking
    always @(posedge clk)
    begin
        loop_out_t want;
        in_taken <= s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
            expected_out.push_back(run_loop_step(s_tdata));
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_out.size() == 0)
                report_mismatch("unexpected result", m_tdata[31:0], 32'd0);
            else
            begin
                want = expected_out.pop_front();
                if (m_tdata[11:0] !== want.pwm_a)
                    report_mismatch("pwm_a", m_tdata[11:0], want.pwm_a);
                if (m_tdata[23:12] !== want.pwm_b)
                    report_mismatch("pwm_b", m_tdata[23:12], want.pwm_b);
                if (m_tdata[35:24] !== want.pwm_c)
                    report_mismatch("pwm_c", m_tdata[35:24], want.pwm_c);
                if (m_tdata[51:36] !== want.current_d)
                    report_mismatch("current_d", m_tdata[51:36], want.current_d);
                if (m_tdata[67:52] !== want.current_q)
                    report_mismatch("current_q", m_tdata[67:52], want.current_q);
                if (m_tdata[83:68] !== want.rotor_angle)
                    report_mismatch("rotor_angle", m_tdata[83:68], want.rotor_angle);
                if (m_tdata[84] !== want.hall_fault)
                    report_mismatch("hall_fault", m_tdata[84], want.hall_fault);
                if (m_tdata[85] !== want.interp_on)
                    report_mismatch("interp_on", m_tdata[85], want.interp_on);
            end
            results_seen++;
        end
    end

    // item driver and receiver stalls
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || in_taken)
            begin
                if (pending_items.size() != 0 && !send_hold &&
                    $urandom_range(0, 99) >= send_idle_pct)
                begin
                    s_tdata  <= pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    items_sent++;
                end
                else
                    s_tvalid <= 1'b0;
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles with no handshake on any channel
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d results outstanding", expected_out.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_reg(cfg_index_t idx, logic [23:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_CURRENT_OFFSET: current_offset = value[11:0];
            CFG_AMPS_PER_COUNT: amps_per_count = value[15:0];
            CFG_KI_Q:           ki_q           = value;
            CFG_KI_D:           ki_d           = value;
            CFG_INTEG_LIMIT:    integ_limit    = value[14:0];
            CFG_PWM_CENTER:     pwm_center     = value[11:0];
            CFG_PWM_GAIN:       pwm_gain       = value[11:0];
            default:            stall_ticks    = value[15:0];
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all(logic [11:0] offs, logic [15:0] apc, logic [23:0] kq,
                             logic [23:0] kd, logic [14:0] lim, logic [11:0] ctr,
                             logic [11:0] gain, logic [15:0] stall);
        write_reg(CFG_CURRENT_OFFSET, 24'(offs));
        write_reg(CFG_AMPS_PER_COUNT, 24'(apc));
        write_reg(CFG_KI_Q, kq);
        write_reg(CFG_KI_D, kd);
        write_reg(CFG_INTEG_LIMIT, 24'(lim));
        write_reg(CFG_PWM_CENTER, 24'(ctr));
        write_reg(CFG_PWM_GAIN, 24'(gain));
        write_reg(CFG_STALL_TICKS, 24'(stall));
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || s_tvalid || expected_out.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [79:0] pack_item(logic [11:0] c_code, logic [11:0] b_code,
                                               logic [2:0] halls, logic [31:0] now,
                                               logic [15:0] target);
        return {5'd0, target, now, halls, b_code, c_code};
    endfunction

    function automatic logic [11:0] shunt_code();
        int v;
        if ($urandom_range(0, 1) == 0)
            return 12'($urandom_range(0, 4095));
        v = int'(current_offset) + int'($urandom_range(0, 400)) - 200;
        return 12'(v < 0 ? 0 : (v > 4095 ? 4095 : v));
    endfunction

    // mostly a rotating hall sequence with random content, some noise
    function automatic logic [79:0] random_item();
        logic [2:0]  halls;
        logic [15:0] target;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 80)
        begin
            gen_tick += $urandom_range(1, 400);
            if (pick < 4)
                gen_tick += $urandom_range(1000, 40000);
            if ($urandom_range(0, 39) == 0)
                gen_dir = -gen_dir;
            if ($urandom_range(0, 2) == 0)
                gen_pos = (gen_pos + gen_dir + 6) % 6;
            halls = fwd_order[gen_pos];
        end
        else
        begin
            halls = 3'($urandom_range(0, 7));
            if ($urandom_range(0, 1) == 0)
                gen_tick = $urandom;
            else
                gen_tick += $urandom_range(0, 100000);
        end
        target = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2047) - 1024);
        return pack_item(shunt_code(), shunt_code(), halls, gen_tick, target);
    endfunction

    task automatic push_random(int count);
        for (int i = 0; i < count; i++)
            pending_items.push_back(random_item());
    endtask

    // directed items at reset configuration
    task automatic push_directed();
        pending_items.push_back(pack_item(12'd2050, 12'd2050, 3'd1, 32'd100, 16'sd0));
        pending_items.push_back(pack_item(12'd0, 12'd4095, 3'd3, 32'd200, 16'h7FFF));
        pending_items.push_back(pack_item(12'd4095, 12'd0, 3'd3, 32'd250, 16'h8000));
        pending_items.push_back(pack_item(12'd0, 12'd0, 3'd2, 32'd300, 16'h8000));
        pending_items.push_back(pack_item(12'd4095, 12'd4095, 3'd6, 32'd400, 16'h7FFF));
        // stall: long wait in one sector
        pending_items.push_back(pack_item(12'd2050, 12'd2050, 3'd6, 32'd1000, 16'd100));
        // reversal
        pending_items.push_back(pack_item(12'd2000, 12'd2100, 3'd2, 32'd1100, 16'hFF9C));
        pending_items.push_back(pack_item(12'd2100, 12'd2000, 3'd3, 32'd1200, 16'd0));
        pending_items.push_back(pack_item(12'd2100, 12'd2000, 3'd3, 32'd1260, 16'd0));
        // invalid hall codes
        pending_items.push_back(pack_item(12'd1500, 12'd2600, 3'd0, 32'd1300, 16'd500));
        pending_items.push_back(pack_item(12'd2600, 12'd1500, 3'd7, 32'd1400, 16'd500));
        pending_items.push_back(pack_item(12'd2050, 12'd2050, 3'd5, 32'd1500, 16'd0));
        // tick counter wraps
        pending_items.push_back(pack_item(12'd2050, 12'd2050, 3'd1, 32'hFFFF_FF00, 16'd0));
        pending_items.push_back(pack_item(12'd1800, 12'd2300, 3'd3, 32'd60, 16'd2000));
        pending_items.push_back(pack_item(12'd1800, 12'd2300, 3'd2, 32'd400, 16'd2000));
        pending_items.push_back(pack_item(12'd1800, 12'd2300, 3'd6, 32'd740, 16'd2000));
        pending_items.push_back(pack_item(12'd1800, 12'd2300, 3'd6, 32'd900, 16'd2000));
        pending_items.push_back(pack_item(12'd1800, 12'd2300, 3'd4, 32'd1000, 16'd2000));
        pending_items.push_back(pack_item(12'd1800, 12'd2300, 3'd5, 32'd1040, 16'hF000));
        pending_items.push_back(pack_item(12'd1800, 12'd2300, 3'd1, 32'd1080, 16'hF000));
    endtask

    // sequence of phases
    initial
    begin
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_CURRENT_OFFSET;
        cfg_data       = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        in_taken       = 1'b0;
        send_hold      = 1'b0;
        error_count    = 0;
        items_sent     = 0;
        results_seen   = 0;
        idle_cycles    = 0;
        current_offset = 12'd2050;
        amps_per_count = 16'd1756;
        ki_q           = 24'd16777;
        ki_d           = 24'd1678;
        integ_limit    = 15'd16384;
        pwm_center     = 12'd2000;
        pwm_gain       = 12'd500;
        stall_ticks    = 16'd5000;
        last_hall      = 3'd0;
        rot_dir        = DIR_NONE;
        interp_armed   = 1'b0;
        fault_seen     = 1'b0;
        last_edge      = '0;
        sector_period  = '0;
        integ_d_acc    = 0;
        integ_q_acc    = 0;
        gen_tick       = 32'd2000;
        gen_pos        = 0;
        gen_dir        = 1;
        build_sine();
        send_idle_pct  = 18;
        recv_idle_pct  = 75;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset configuration
        push_directed();
        push_random(230);
        wait_drained();

        // every register at its top value
        write_all(12'd4095, 16'd65535, 24'hFFFFFF, 24'hFFFFFF, 15'h7FFF,
                  12'd4095, 12'd4095, 16'd65535);
        push_random(250);
        wait_drained();

        // every register at zero, with a full pause of the sender midway
        send_idle_pct = 75;
        recv_idle_pct = 18;
        write_all(12'd0, 16'd0, 24'd0, 24'd0, 15'd0, 12'd0, 12'd0, 16'd0);
        push_random(250);
        while (pending_items.size() > 125)
            @(posedge clk);
        send_hold = 1'b1;
        while (s_tvalid || expected_out.size() != 0)
            @(posedge clk);
        send_hold = 1'b0;
        wait_drained();

        // random settings
        write_all(12'($urandom), 16'($urandom), 24'($urandom), 24'($urandom),
                  15'($urandom), 12'($urandom), 12'($urandom), 16'($urandom));
        push_random(250);
        wait_drained();

        // no idling from here on
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_all(12'd2050, 16'd1756, 24'd400000, 24'd200000, 15'd16384,
                  12'd2000, 12'd1500, 16'd5000);
        push_random(250);
        wait_drained();

        write_all(12'($urandom_range(1900, 2200)), 16'($urandom), 24'($urandom),
                  24'($urandom), 15'($urandom), 12'($urandom), 12'($urandom),
                  16'($urandom_range(1000, 65535)));
        push_random(250);
        wait_drained();

        $display("sent %0d items and checked %0d results over six register settings",
                 items_sent, results_seen);
        $display("phases ran with sender stalls, receiver stalls and no stalls");
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: hall_foc_current_loop_unit.f
+incdir+rtl/core
rtl/core/hfcl_pkg.sv
rtl/core/hall_foc_current_loop_unit.sv
tb/tb_hall_foc_current_loop_unit.sv
